// File: sv/cps_pkg.sv
// ----------------------------------------------------------------------------
// Closest pair search package
// Shared payload types, ring control group and sequencer states.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int FIELD_W    = 16;
    localparam int IDX_OUT_W  = 8;
    localparam int DIST_OUT_W = 33;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic                      last_point;
    } in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]  first_index;
        logic [IDX_OUT_W-1:0]  second_index;
        logic [DIST_OUT_W-1:0] squared_distance;
        logic                  result_valid;
    } out_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic recirc;
    } ring_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ANCHOR,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

endpackage

// File: sv/closest_pair_search_core.sv
// ----------------------------------------------------------------------------
// Closest pair search core
// Loads points into a ring of cells and finds the pair with the smallest
// squared distance.
// ----------------------------------------------------------------------------
// Each accepted point transfer is stored in the next free cell of the ring,
// if one is free. The transfer flagged as the last point starts the search,
// during which no input is accepted: anchor and comparison rounds run over
// the stored points and the distance pipeline is drained before the result
// is offered. A single distance unit evaluates one pair per cycle. A set with
// fewer than two points gives an invalid result in the cycle after the last
// transfer.
module closest_pair_search_core
    import cps_pkg::*;
#(
    parameter int MAX_POINTS  = 256,
    parameter int COORD_WIDTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int LW = $clog2(MAX_POINTS + 1);
    localparam int SW = 2 * CW + 1;
    localparam logic [LW-1:0] DEPTH = LW'(MAX_POINTS);
    localparam logic [LW-1:0] ONE   = LW'(1);
    localparam logic [LW-1:0] TWO   = LW'(2);

    state_t        state_reg, state_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] scan_reg, scan_next;
    logic          first_reg, first_next;
    logic [CW-1:0] ax_reg, ay_reg;
    logic [IW-1:0] ai_reg;
    out_t          res_reg, res_next;

    ring_ctrl_t    ctrl;
    logic          anchor_ld;
    logic          issue;
    logic          not_full;
    logic [LW-1:0] n_pts;

    logic [CW+FIELD_W-1:0] xw, yw;
    logic [CW-1:0]         wr_x, wr_y;

    logic [CW-1:0] cx   [MAX_POINTS];
    logic [CW-1:0] cy   [MAX_POINTS];
    logic [IW-1:0] cidx [MAX_POINTS];

    logic [IW-1:0] best_i, best_j;
    logic [SW-1:0] best_d;
    logic          busy;

    logic [IW+IDX_OUT_W-1:0]  bi_w, bj_w;
    logic [SW+DIST_OUT_W-1:0] bd_w;

    assign xw   = {{CW{1'b0}}, s_payload.point_x};
    assign yw   = {{CW{1'b0}}, s_payload.point_y};
    assign wr_x = xw[CW-1:0];
    assign wr_y = yw[CW-1:0];

    generate
        for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
            localparam int NB = (k == MAX_POINTS - 1) ? k : k + 1;
            cps_cell #(
                .CW         (CW),
                .IW         (IW),
                .LW         (LW),
                .CELL_INDEX (k)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .count    (count_reg),
                .len      (len_reg),
                .wr_x     (wr_x),
                .wr_y     (wr_y),
                .nbr_x    (cx[NB]),
                .nbr_y    (cy[NB]),
                .nbr_idx  (cidx[NB]),
                .head_x   (cx[0]),
                .head_y   (cy[0]),
                .head_idx (cidx[0]),
                .x        (cx[k]),
                .y        (cy[k]),
                .idx      (cidx[k])
            );
        end
    endgenerate

    cps_dist #(
        .CW (CW),
        .IW (IW),
        .SW (SW)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .first   (first_reg),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .ai      (ai_reg),
        .bx      (cx[0]),
        .by      (cy[0]),
        .bi      (cidx[0]),
        .best_i  (best_i),
        .best_j  (best_j),
        .best_d  (best_d),
        .busy    (busy)
    );

    assign bi_w = {{IDX_OUT_W{1'b0}}, best_i};
    assign bj_w = {{IDX_OUT_W{1'b0}}, best_j};
    assign bd_w = {{DIST_OUT_W{1'b0}}, best_d};

    assign not_full = (count_reg < DEPTH);
    assign n_pts    = count_reg + LW'(not_full);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        scan_next   = scan_reg;
        first_next  = first_reg;
        res_next    = res_reg;
        ctrl        = '0;
        anchor_ld   = 1'b0;
        issue       = 1'b0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load  = not_full;
                    count_next = n_pts;
                    if (s_payload.last_point) begin
                        count_next = '0;
                        if (n_pts < TWO) begin
                            res_next   = '0;
                            state_next = ST_OUT;
                        end else begin
                            len_next   = n_pts;
                            first_next = 1'b1;
                            state_next = ST_ANCHOR;
                        end
                    end
                end
            end
            ST_ANCHOR: begin
                anchor_ld  = 1'b1;
                ctrl.shift = 1'b1;
                len_next   = len_reg - ONE;
                scan_next  = len_reg - ONE;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                issue       = 1'b1;
                first_next  = 1'b0;
                ctrl.shift  = 1'b1;
                ctrl.recirc = 1'b1;
                scan_next   = scan_reg - ONE;
                if (scan_reg == ONE) begin
                    state_next = (len_reg >= TWO) ? ST_ANCHOR : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    res_next.first_index      = bi_w[IDX_OUT_W-1:0];
                    res_next.second_index     = bj_w[IDX_OUT_W-1:0];
                    res_next.squared_distance = bd_w[DIST_OUT_W-1:0];
                    res_next.result_valid     = 1'b1;
                    state_next                = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            len_reg   <= '0;
            scan_reg  <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            scan_reg  <= scan_next;
            first_reg <= first_next;
        end
        res_reg <= res_next;
        if (anchor_ld) begin
            ax_reg <= cx[0];
            ay_reg <= cy[0];
            ai_reg <= cidx[0];
        end
    end

    assign m_payload = res_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH)
        else $error("point count exceeds store depth");

    a_scan_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_reg != '0)
        else $error("scan entered with no partner left");

    a_anchor_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ANCHOR |-> len_reg >= TWO)
        else $error("anchor round started with fewer than two points");

    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> !busy)
        else $error("result offered while distance pipeline busy");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (MAX_POINTS <= 256) && m_valid && m_payload.result_valid
        |-> m_payload.first_index < m_payload.second_index)
        else $error("closest pair indices out of order");

endmodule

// File: sv/cps_cell.sv
// ----------------------------------------------------------------------------
// Closest pair search ring cell
// Holds one stored point and its index, and moves it towards the head of the
// ring during the search.
// ----------------------------------------------------------------------------
module cps_cell
    import cps_pkg::*;
#(
    parameter int CW         = 16,
    parameter int IW         = 8,
    parameter int LW         = 9,
    parameter int CELL_INDEX = 0
) (
    input  logic          aclk,
    input  ring_ctrl_t    ctrl,
    input  logic [LW-1:0] count,
    input  logic [LW-1:0] len,
    input  logic [CW-1:0] wr_x,
    input  logic [CW-1:0] wr_y,
    input  logic [CW-1:0] nbr_x,
    input  logic [CW-1:0] nbr_y,
    input  logic [IW-1:0] nbr_idx,
    input  logic [CW-1:0] head_x,
    input  logic [CW-1:0] head_y,
    input  logic [IW-1:0] head_idx,
    output logic [CW-1:0] x,
    output logic [CW-1:0] y,
    output logic [IW-1:0] idx
);

    localparam logic [LW-1:0] POS = LW'(CELL_INDEX);
    localparam logic [LW-1:0] END = LW'(CELL_INDEX + 1);
    localparam logic [IW-1:0] OWN = IW'(CELL_INDEX);

    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [IW-1:0] idx_reg, idx_next;

    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        idx_next = idx_reg;
        if (ctrl.load && count == POS) begin
            x_next   = wr_x;
            y_next   = wr_y;
            idx_next = OWN;
        end else if (ctrl.shift) begin
            if (ctrl.recirc && len == END) begin
                x_next   = head_x;
                y_next   = head_y;
                idx_next = head_idx;
            end else begin
                x_next   = nbr_x;
                y_next   = nbr_y;
                idx_next = nbr_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        idx_reg <= idx_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign idx = idx_reg;

endmodule

// File: sv/cps_dist.sv
// ----------------------------------------------------------------------------
// Closest pair search distance unit
// Three-stage pipeline: absolute differences, squares, then sum and
// comparison against the best pair so far.
// ----------------------------------------------------------------------------
module cps_dist #(
    parameter int CW = 16,
    parameter int IW = 8,
    parameter int SW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          issue,
    input  logic          first,
    input  logic [CW-1:0] ax,
    input  logic [CW-1:0] ay,
    input  logic [IW-1:0] ai,
    input  logic [CW-1:0] bx,
    input  logic [CW-1:0] by,
    input  logic [IW-1:0] bi,
    output logic [IW-1:0] best_i,
    output logic [IW-1:0] best_j,
    output logic [SW-1:0] best_d,
    output logic          busy
);

    logic signed [CW:0] dx_s, dy_s, dx_n, dy_n;
    logic [CW-1:0]      dx_next, dy_next;

    logic               v1_reg, f1_reg;
    logic [CW-1:0]      dx_reg, dy_reg;
    logic [IW-1:0]      i1_reg, j1_reg;

    logic               v2_reg, f2_reg;
    logic [2*CW-1:0]    sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [IW-1:0]      i2_reg, j2_reg;

    logic [SW-1:0]      sum;
    logic               take;
    logic [IW-1:0]      bi_reg, bj_reg;
    logic [SW-1:0]      bd_reg;

    always_comb begin
        dx_s     = $signed({ax[CW-1], ax}) - $signed({bx[CW-1], bx});
        dy_s     = $signed({ay[CW-1], ay}) - $signed({by[CW-1], by});
        dx_n     = -dx_s;
        dy_n     = -dy_s;
        dx_next  = dx_s[CW] ? dx_n[CW-1:0] : dx_s[CW-1:0];
        dy_next  = dy_s[CW] ? dy_n[CW-1:0] : dy_s[CW-1:0];
        sqx_next = {{CW{1'b0}}, dx_reg} * {{CW{1'b0}}, dx_reg};
        sqy_next = {{CW{1'b0}}, dy_reg} * {{CW{1'b0}}, dy_reg};
        sum      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        take     = v2_reg && (f2_reg || sum < bd_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
        f1_reg  <= first;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        i1_reg  <= ai;
        j1_reg  <= bi;
        f2_reg  <= f1_reg;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        i2_reg  <= i1_reg;
        j2_reg  <= j1_reg;
        if (take) begin
            bi_reg <= i2_reg;
            bj_reg <= j2_reg;
            bd_reg <= sum;
        end
    end

    assign best_i = bi_reg;
    assign best_j = bj_reg;
    assign best_d = bd_reg;
    assign busy   = v1_reg | v2_reg;

endmodule
